// File: design/plc_pkg.sv
package plc_pkg;

    localparam int TABLE_DEPTH_DEF = 128;
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int THR_W           = 18;
    localparam int HIT_W           = 16;
    localparam int SCORE_W         = 31;
    localparam int QUEUE_DEPTH     = 2;
    localparam logic [THR_W-1:0] THR_RESET = 18'd410;
    localparam logic [HIT_W-1:0] HIT_MAX   = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_MUL,
        ST_OFFER
    } t_state;

endpackage

// File: design/pattern_leader_clustering_top.sv
// channel   dir   beat                                        handshake
// cfg       in    match_threshold                             i_cfg_valid / o_cfg_ready
// episode   in    energy, risk, reward, significance          i_valid / o_ready
// result    out   slot, inserted, dropped, best_*             o_valid / i_ready
//
// each stored pattern is read (ST_RD) and compared (ST_CMP) in turn; a match goes on to ST_MUL then ST_OFFER
// with no match: ST_MUL then ST_OFFER to insert, or straight to ST_OFFER to drop when full
// the offer cycle repeats while the result register holds an unaccepted beat
// a two-entry episode queue lets new beats arrive while a scan runs
// the result register holds one finished beat while the next episode is worked on
// synchronous active-low reset empties the table and the queue, threshold back to 410
module pattern_leader_clustering_top #(
    parameter int TABLE_DEPTH = plc_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = plc_pkg::VALUE_WIDTH_DEF,
    localparam int SW = $clog2(TABLE_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [plc_pkg::THR_W-1:0]     i_match_threshold,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_energy_in,
    input  logic signed [VALUE_WIDTH-1:0] i_risk_in,
    input  logic signed [VALUE_WIDTH-1:0] i_reward_in,
    input  logic [VALUE_WIDTH-2:0]        i_significance_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [SW-1:0]                 o_slot,
    output logic                          o_inserted,
    output logic                          o_dropped,
    output logic [SW-1:0]                 o_best_slot,
    output logic [plc_pkg::SCORE_W-1:0]   o_best_score,
    output logic signed [VALUE_WIDTH-1:0] o_best_energy,
    output logic signed [VALUE_WIDTH-1:0] o_best_risk,
    output logic signed [VALUE_WIDTH-1:0] o_best_reward
);

    localparam int EW = 4 * VALUE_WIDTH - 1;

    logic [plc_pkg::THR_W-1:0] r_thr;
    logic                      w_q_valid;
    logic                      w_q_ready;
    logic [EW-1:0]             w_q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= plc_pkg::THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_match_threshold;
        end
    end

    plc_queue #(
        .DATA_W (EW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  ({i_significance_in, i_reward_in, i_risk_in, i_energy_in}),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_data)
    );

    plc_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_thr         (r_thr),
        .i_ep_valid    (w_q_valid),
        .o_ep_ready    (w_q_ready),
        .i_ep          (w_q_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_slot        (o_slot),
        .o_inserted    (o_inserted),
        .o_dropped     (o_dropped),
        .o_best_slot   (o_best_slot),
        .o_best_score  (o_best_score),
        .o_best_energy (o_best_energy),
        .o_best_risk   (o_best_risk),
        .o_best_reward (o_best_reward)
    );

endmodule

// File: design/plc_queue.sv
module plc_queue #(
    parameter int DATA_W = 63
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data
);

    localparam int PW = $clog2(plc_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(plc_pkg::QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [plc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_rp;
    logic [CW-1:0]     r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_ready = r_cnt != CW'(plc_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(plc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(plc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: design/plc_engine.sv
module plc_engine #(
    parameter int TABLE_DEPTH = plc_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = plc_pkg::VALUE_WIDTH_DEF,
    localparam int SW = $clog2(TABLE_DEPTH),
    localparam int EW = 4 * VALUE_WIDTH - 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [plc_pkg::THR_W-1:0]       i_thr,
    input  logic                            i_ep_valid,
    output logic                            o_ep_ready,
    input  logic [EW-1:0]                   i_ep,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [SW-1:0]                   o_slot,
    output logic                            o_inserted,
    output logic                            o_dropped,
    output logic [SW-1:0]                   o_best_slot,
    output logic [plc_pkg::SCORE_W-1:0]     o_best_score,
    output logic signed [VALUE_WIDTH-1:0]   o_best_energy,
    output logic signed [VALUE_WIDTH-1:0]   o_best_risk,
    output logic signed [VALUE_WIDTH-1:0]   o_best_reward
);

    localparam int VW  = VALUE_WIDTH;
    localparam int FW  = $clog2(TABLE_DEPTH + 1);
    localparam int CEW = 3 * VW;
    localparam int DW  = VW + 3;
    localparam int KW  = (DW > plc_pkg::THR_W) ? DW : plc_pkg::THR_W;
    localparam int PRW = VW - 1 + plc_pkg::HIT_W;

    plc_pkg::t_state r_state;
    plc_pkg::t_state n_state;

    logic [CEW-1:0]            r_cent_mem  [TABLE_DEPTH];
    logic [plc_pkg::HIT_W-1:0] r_hit_mem   [TABLE_DEPTH];
    logic [VW-2:0]             r_worth_mem [TABLE_DEPTH];
    logic [CEW-1:0]            r_cent_q;
    logic [plc_pkg::HIT_W-1:0] r_hit_q;
    logic [VW-2:0]             r_worth_q;

    logic [FW-1:0]             r_filled;
    logic [FW-1:0]             r_idx;
    logic [VW-2:0]             r_mw;
    logic [plc_pkg::HIT_W-1:0] r_mh;
    logic [SW-1:0]             r_cand;
    logic [CEW-1:0]            r_cand_cent;
    logic                      r_ins;
    logic                      r_drop;
    logic                      r_upd;
    logic [plc_pkg::SCORE_W-1:0] r_score;
    logic [SW-1:0]             r_lslot;
    logic [plc_pkg::SCORE_W-1:0] r_lscore;
    logic [CEW-1:0]            r_lcent;

    logic                      w_full;
    logic                      w_more;
    logic                      w_match;
    logic                      w_out_free;
    logic                      w_take;
    logic [plc_pkg::HIT_W-1:0] w_hit_inc;
    logic [PRW-1:0]            w_prod;
    logic [DW-1:0]             w_dist;
    logic signed [VW:0]        w_d0, w_d1, w_d2;
    logic signed [VW-1:0]      w_d3;
    logic [VW:0]               w_a0, w_a1, w_a2;
    logic [VW-1:0]             w_a3;
    logic                      w_beat;
    logic [SW-1:0]             w_nslot;
    logic [plc_pkg::SCORE_W-1:0] w_nscore;
    logic [CEW-1:0]            w_ncent;

    assign w_full     = r_filled == FW'(TABLE_DEPTH);
    assign w_more     = r_idx < r_filled;
    assign w_out_free = !o_valid || i_ready;
    assign w_take     = (r_state == plc_pkg::ST_OFFER) && w_out_free;
    assign o_ep_ready = w_take;
    assign w_hit_inc  = (r_hit_q == plc_pkg::HIT_MAX) ? r_hit_q : r_hit_q + 1'b1;
    assign w_prod     = PRW'(r_mw) * PRW'(r_mh);

    // l1 distance between queued episode and the slot read last cycle
    always_comb begin
        w_d0 = $signed({i_ep[VW-1], i_ep[VW-1:0]})
             - $signed({r_cent_q[VW-1], r_cent_q[VW-1:0]});
        w_d1 = $signed({i_ep[2*VW-1], i_ep[2*VW-1:VW]})
             - $signed({r_cent_q[2*VW-1], r_cent_q[2*VW-1:VW]});
        w_d2 = $signed({i_ep[3*VW-1], i_ep[3*VW-1:2*VW]})
             - $signed({r_cent_q[3*VW-1], r_cent_q[3*VW-1:2*VW]});
        w_d3 = $signed({1'b0, i_ep[EW-1:3*VW]}) - $signed({1'b0, r_worth_q});
        w_a0 = w_d0[VW] ? (VW+1)'(0) - w_d0 : w_d0;
        w_a1 = w_d1[VW] ? (VW+1)'(0) - w_d1 : w_d1;
        w_a2 = w_d2[VW] ? (VW+1)'(0) - w_d2 : w_d2;
        w_a3 = w_d3[VW-1] ? VW'(0) - w_d3 : w_d3;
        w_dist = DW'(w_a0) + DW'(w_a1) + DW'(w_a2) + DW'(w_a3);
        w_match = KW'(w_dist) < KW'(i_thr);
    end

    // on equal score the lower or same slot wins, so the same slot reloads its centroid
    always_comb begin
        w_beat   = r_upd && ((r_score > r_lscore)
                   || (r_score == r_lscore && r_cand <= r_lslot));
        w_nslot  = w_beat ? r_cand : r_lslot;
        w_nscore = w_beat ? r_score : r_lscore;
        w_ncent  = w_beat ? r_cand_cent : r_lcent;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plc_pkg::ST_IDLE:  if (i_ep_valid) n_state = plc_pkg::ST_RD;
            plc_pkg::ST_RD: begin
                if (w_more) n_state = plc_pkg::ST_CMP;
                else if (!w_full) n_state = plc_pkg::ST_MUL;
                else n_state = plc_pkg::ST_OFFER;
            end
            plc_pkg::ST_CMP:   n_state = w_match ? plc_pkg::ST_MUL : plc_pkg::ST_RD;
            plc_pkg::ST_MUL:   n_state = plc_pkg::ST_OFFER;
            plc_pkg::ST_OFFER: if (w_out_free) n_state = plc_pkg::ST_IDLE;
            default:           n_state = plc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= plc_pkg::ST_IDLE;
            r_filled <= '0;
            r_lslot  <= '0;
            r_lscore <= '0;
            r_lcent  <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == plc_pkg::ST_RD && !w_more && !w_full) begin
                r_filled <= r_filled + 1'b1;
            end
            if (w_take) begin
                r_lslot  <= w_nslot;
                r_lscore <= w_nscore;
                r_lcent  <= w_ncent;
                o_valid  <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            plc_pkg::ST_IDLE: begin
                r_idx  <= '0;
                r_drop <= 1'b0;
                r_ins  <= 1'b0;
                r_upd  <= 1'b0;
            end
            plc_pkg::ST_RD: begin
                if (!w_more) begin
                    r_cand      <= r_filled[SW-1:0];
                    r_cand_cent <= i_ep[CEW-1:0];
                    r_mw        <= i_ep[EW-1:CEW];
                    r_mh        <= plc_pkg::HIT_W'(1);
                    r_ins       <= !w_full;
                    r_drop      <= w_full;
                end
            end
            plc_pkg::ST_CMP: begin
                if (w_match) begin
                    r_cand      <= r_idx[SW-1:0];
                    r_cand_cent <= r_cent_q;
                    r_mw        <= r_worth_q;
                    r_mh        <= w_hit_inc;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            plc_pkg::ST_MUL: begin
                r_score <= plc_pkg::SCORE_W'(w_prod);
                r_upd   <= 1'b1;
            end
            plc_pkg::ST_OFFER: begin
                if (w_out_free) begin
                    o_slot        <= r_drop ? '0 : r_cand;
                    o_inserted    <= r_ins;
                    o_dropped     <= r_drop;
                    o_best_slot   <= w_nslot;
                    o_best_score  <= w_nscore;
                    o_best_energy <= w_ncent[VW-1:0];
                    o_best_risk   <= w_ncent[2*VW-1:VW];
                    o_best_reward <= w_ncent[3*VW-1:2*VW];
                end
            end
            default: r_idx <= '0;
        endcase
    end

    // pattern store
    always_ff @(posedge i_clk) begin
        if (r_state == plc_pkg::ST_RD && !w_more && !w_full) begin
            r_cent_mem[r_filled[SW-1:0]]  <= i_ep[CEW-1:0];
            r_worth_mem[r_filled[SW-1:0]] <= i_ep[EW-1:CEW];
        end
        r_cent_q  <= r_cent_mem[r_idx[SW-1:0]];
        r_worth_q <= r_worth_mem[r_idx[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == plc_pkg::ST_RD && !w_more && !w_full) begin
            r_hit_mem[r_filled[SW-1:0]] <= plc_pkg::HIT_W'(1);
        end else if (r_state == plc_pkg::ST_CMP && w_match) begin
            r_hit_mem[r_idx[SW-1:0]] <= w_hit_inc;
        end
        r_hit_q <= r_hit_mem[r_idx[SW-1:0]];
    end

endmodule

// File: design/plc_checker.sv
module plc_checker #(
    parameter int TABLE_DEPTH = plc_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = plc_pkg::VALUE_WIDTH_DEF,
    localparam int SW = $clog2(TABLE_DEPTH)
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [SW-1:0]                 o_slot,
    input logic                          o_inserted,
    input logic                          o_dropped,
    input logic [plc_pkg::SCORE_W-1:0]   o_best_score
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_slot) && $stable(o_best_score))
        else $error("stalled result changed");

    a_drop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dropped |-> !o_inserted && o_slot == '0)
        else $error("dropped beat also inserted or has a slot");

    a_score_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready ##1 o_valid && $changed(o_best_score)
            |-> o_best_score > $past(o_best_score))
        else $error("best score went down");

endmodule

bind pattern_leader_clustering_top plc_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_plc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_slot       (o_slot),
    .o_inserted   (o_inserted),
    .o_dropped    (o_dropped),
    .o_best_score (o_best_score)
);
